### rtl/core/bpg_pkg.sv
// Shared types, codes and helper functions of the bouncing playhead grid.
// Used by bpg_cell and bouncing_playhead_grid; depends on nothing else.
package bpg_pkg;

  // Defaults for the top level parameters
  localparam int MAX_HEADS_DEF = 16;
  localparam int GRID_MAX_DEF  = 64;

  // Configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 1'b1;
  localparam logic [6:0] DIM_RESET = 7'd8;

  // Input operations
  localparam logic OP_BEAT   = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_WALL    = 3'd0;
  localparam logic [2:0] KIND_DONE    = 3'd1;
  localparam logic [2:0] KIND_ADDED   = 3'd2;
  localparam logic [2:0] KIND_REMOVED = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;

  // Headings
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD      = 3'd0,
    CMD_MOVE      = 3'd1,
    CMD_SCAN_LOAD = 3'd2,
    CMD_SCAN_STEP = 3'd3,
    CMD_TURN      = 3'd4,
    CMD_TAKE      = 3'd5
  } cell_cmd_t;

  // Per-cell control: command, cell holds a live head, cell takes neighbor data
  typedef struct packed {
    cell_cmd_t cmd;
    logic      live;
    logic      pick;
  } cell_ctl_t;

  // Turn right t times (clockwise order up, right, down, left)
  function automatic logic [1:0] turn_by(input logic [1:0] d, input logic [1:0] t);
    logic [1:0] p;
    logic [1:0] q;
    logic [1:0] r;
    case (d)
      DIR_UP:    p = 2'd0;
      DIR_RIGHT: p = 2'd1;
      DIR_DOWN:  p = 2'd2;
      default:   p = 2'd3;
    endcase
    q = p + t;
    case (q)
      2'd0:    r = DIR_UP;
      2'd1:    r = DIR_RIGHT;
      2'd2:    r = DIR_DOWN;
      default: r = DIR_LEFT;
    endcase
    return r;
  endfunction

  // Opposite heading
  function automatic logic [1:0] reverse_dir(input logic [1:0] d);
    logic [1:0] r;
    case (d)
      DIR_UP:    r = DIR_DOWN;
      DIR_DOWN:  r = DIR_UP;
      DIR_LEFT:  r = DIR_RIGHT;
      default:   r = DIR_LEFT;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/bpg_cell.sv
// One cell of the playhead row: holds one head and a circulating token.
// Depends on bpg_pkg for the command codes and heading helpers.
module bpg_cell #(
  parameter int CW = 6
) (
  input  logic                clk,
  input  bpg_pkg::cell_ctl_t  ctl_i,
  input  logic [CW-1:0]       wm1_i,
  input  logic [CW-1:0]       hm1_i,
  input  logic [CW-1:0]       nb_x_i,
  input  logic [CW-1:0]       nb_y_i,
  input  logic [1:0]          nb_dir_i,
  input  logic [CW-1:0]       nb_tx_i,
  input  logic [CW-1:0]       nb_ty_i,
  input  logic                nb_tv_i,
  output logic [CW-1:0]       x_o,
  output logic [CW-1:0]       y_o,
  output logic [1:0]          dir_o,
  output logic [CW-1:0]       tx_o,
  output logic [CW-1:0]       ty_o,
  output logic                tv_o
);

  logic [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [CW-1:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic          tv_r, tv_nxt;
  logic [1:0]    turn_r, turn_nxt;
  logic [CW-1:0] xc, yc;
  logic          tok_hit;

  // Pull a head that sits off a shrunken grid back onto it
  assign xc = (x_r > wm1_i) ? wm1_i : x_r;
  assign yc = (y_r > hm1_i) ? hm1_i : y_r;

  // Passing token belongs to another live head on this cell
  assign tok_hit = ctl_i.live && nb_tv_i && (nb_tx_i == x_r) && (nb_ty_i == y_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    dir_nxt  = dir_r;
    tx_nxt   = tx_r;
    ty_nxt   = ty_r;
    tv_nxt   = tv_r;
    turn_nxt = turn_r;
    case (ctl_i.cmd)
      bpg_pkg::CMD_MOVE: begin
        // Step one cell, saturate at the edge
        x_nxt = xc;
        y_nxt = yc;
        case (dir_r)
          bpg_pkg::DIR_UP: begin
            if (yc < hm1_i) y_nxt = yc + CW'(1);
          end
          bpg_pkg::DIR_DOWN: begin
            if (yc != '0) y_nxt = yc - CW'(1);
          end
          bpg_pkg::DIR_LEFT: begin
            if (xc != '0) x_nxt = xc - CW'(1);
          end
          default: begin
            if (xc < wm1_i) x_nxt = xc + CW'(1);
          end
        endcase
      end
      bpg_pkg::CMD_SCAN_LOAD: begin
        tx_nxt   = x_r;
        ty_nxt   = y_r;
        tv_nxt   = ctl_i.live;
        turn_nxt = 2'd0;
      end
      bpg_pkg::CMD_SCAN_STEP: begin
        // Pass tokens along the ring, count heads sharing this cell
        tx_nxt = nb_tx_i;
        ty_nxt = nb_ty_i;
        tv_nxt = nb_tv_i;
        if (tok_hit) turn_nxt = turn_r + 2'd1;
      end
      bpg_pkg::CMD_TURN: begin
        dir_nxt = bpg_pkg::turn_by(dir_r, turn_r);
      end
      bpg_pkg::CMD_TAKE: begin
        if (ctl_i.pick) begin
          x_nxt   = nb_x_i;
          y_nxt   = nb_y_i;
          dir_nxt = nb_dir_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    dir_r  <= dir_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    tv_r   <= tv_nxt;
    turn_r <= turn_nxt;
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign dir_o = dir_r;
  assign tx_o  = tx_r;
  assign ty_o  = ty_r;
  assign tv_o  = tv_r;

endmodule

### rtl/core/bouncing_playhead_grid.sv
// Bouncing playhead grid: a row of head cells with a sequencer and output register.
// Depends on bpg_pkg and bpg_cell.
//
// Usage:
//   in_*  : one beat per item. in_tuser is the op (0 beat, 1 toggle); in_tdata carries
//           the cell and the heading of a head to add.
//   out_* : result beats. out_tuser is the kind, out_tlast marks the final result
//           of an input item. A beat yields one wall-hit result per bouncing head in
//           head order, then a done result; a toggle yields one result, or none when
//           its cell lies outside the grid.
//   cfg_* : register writes (grid width, grid height), always ready; write only
//           while the block is idle.
// Timing: a beat loads its done result after the token pass around the cell ring
//   that counts collisions and the full rotation of the row past cell 0 that checks
//   walls. A toggle goes to the edit state on acceptance and loads its result there
//   once the output register is free. One item is in work at a time; in_tready is
//   high while the sequencer is idle, so a new item is taken only after the last.
// Reset clears the head table to empty and both grid sizes to 8. A stalled receiver
//   holds the row where it is until the output register is free again.
module bouncing_playhead_grid #(
  parameter int MAX_HEADS = bpg_pkg::MAX_HEADS_DEF,
  parameter int GRID_MAX  = bpg_pkg::GRID_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,  // cell_x[5:0], cell_y[11:6], new_dir[13:12]
  input  logic                      in_tuser,  // op
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata, // hit_dir[1:0], hit_x[7:2], hit_y[13:8],
                                               // note_lane[19:14], head_count[24:20]
  output logic [2:0]                out_tuser, // kind
  output logic                      out_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bpg_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [6:0]                cfg_data
);

  localparam int CW = $clog2(GRID_MAX);
  localparam int NW = $clog2(MAX_HEADS + 1);
  localparam int KW = $clog2(MAX_HEADS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MOVE = 8'b0000_0010,
    S_LOAD = 8'b0000_0100,
    S_STEP = 8'b0000_1000,
    S_TURN = 8'b0001_0000,
    S_EMIT = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_EDIT = 8'b1000_0000
  } state_t;

  // Largest coordinate for a written grid size, clamped to 2..GRID_MAX
  function automatic logic [8:0] dim_m1(input logic [6:0] v);
    logic [8:0] e;
    e = 9'(v);
    if (e < 9'd2) return 9'd1;
    if (e > 9'(GRID_MAX)) return 9'(GRID_MAX - 1);
    return e - 9'd1;
  endfunction

  state_t        state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] wm1_r, hm1_r;
  logic [CW-1:0] cx_r, cy_r;
  logic [1:0]    nd_r;

  logic          out_valid_r;
  logic [2:0]    out_kind_r;
  logic [1:0]    out_dir_r;
  logic [5:0]    out_x_r, out_y_r, out_lane_r;
  logic [4:0]    out_cnt_r;
  logic          out_last_r;

  logic          in_fire, out_free, out_ld;
  logic [2:0]    ev_kind;
  logic [1:0]    ev_dir;
  logic [5:0]    ev_x, ev_y, ev_lane;
  logic [4:0]    ev_cnt;
  logic          ev_last;

  bpg_pkg::cell_cmd_t cmd;
  logic          pick_all, pick_rm, pick_add, nb_new;

  logic [CW-1:0] in_cx, in_cy;
  logic          in_grid;

  // Cell row wiring
  logic [CW-1:0] hx [MAX_HEADS];
  logic [CW-1:0] hy [MAX_HEADS];
  logic [1:0]    hd [MAX_HEADS];
  logic [CW-1:0] tx [MAX_HEADS];
  logic [CW-1:0] ty [MAX_HEADS];
  logic          tv [MAX_HEADS];
  logic [MAX_HEADS-1:0] match, above;
  logic          any_match;
  logic [1:0]    rm_dir;

  logic          emit_hit, wall;
  logic [1:0]    wrap_dir;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Toggle cell must lie inside the grid
  assign in_grid = (9'(in_tdata[5:0]) <= 9'(wm1_r)) && (9'(in_tdata[11:6]) <= 9'(hm1_r));
  assign in_cx   = CW'(in_tdata[5:0]);
  assign in_cy   = CW'(in_tdata[11:6]);

  // Wall check on the head passing cell 0
  always_comb begin
    case (hd[0])
      bpg_pkg::DIR_UP:   wall = (hy[0] == hm1_r);
      bpg_pkg::DIR_DOWN: wall = (hy[0] == '0);
      bpg_pkg::DIR_LEFT: wall = (hx[0] == '0);
      default:           wall = (hx[0] == wm1_r);
    endcase
  end
  assign emit_hit = (state_r == S_EMIT) && (NW'(k_r) < cnt_r) && wall;
  assign wrap_dir = emit_hit ? bpg_pkg::reverse_dir(hd[0]) : hd[0];

  // Find the highest live head on the toggled cell
  always_comb begin
    logic acc;
    logic [1:0] d;
    acc = 1'b0;
    d   = 2'd0;
    for (int i = MAX_HEADS - 1; i >= 0; i--) begin
      match[i] = (NW'(i) < cnt_r) && (hx[i] == cx_r) && (hy[i] == cy_r);
      above[i] = acc;
      if (match[i] && !acc) d = hd[i];
      acc = acc | match[i];
    end
    any_match = acc;
    rm_dir    = d;
  end

  // Row of cells
  for (genvar i = 0; i < MAX_HEADS; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_HEADS;
    bpg_pkg::cell_ctl_t ctl;
    logic [CW-1:0] nbx, nby;
    logic [1:0]    nbd;

    assign ctl.cmd  = cmd;
    assign ctl.live = (NW'(i) < cnt_r);
    assign ctl.pick = pick_all || (pick_rm && !above[i]) ||
                      (pick_add && (NW'(i) == cnt_r));
    assign nbx = nb_new ? cx_r : hx[NB];
    assign nby = nb_new ? cy_r : hy[NB];
    assign nbd = nb_new ? nd_r : ((i == MAX_HEADS - 1) ? wrap_dir : hd[NB]);

    bpg_cell #(.CW(CW)) u_cell (
      .clk      (clk),
      .ctl_i    (ctl),
      .wm1_i    (wm1_r),
      .hm1_i    (hm1_r),
      .nb_x_i   (nbx),
      .nb_y_i   (nby),
      .nb_dir_i (nbd),
      .nb_tx_i  (tx[NB]),
      .nb_ty_i  (ty[NB]),
      .nb_tv_i  (tv[NB]),
      .x_o      (hx[i]),
      .y_o      (hy[i]),
      .dir_o    (hd[i]),
      .tx_o     (tx[i]),
      .ty_o     (ty[i]),
      .tv_o     (tv[i])
    );
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    cmd       = bpg_pkg::CMD_HOLD;
    pick_all  = 1'b0;
    pick_rm   = 1'b0;
    pick_add  = 1'b0;
    nb_new    = 1'b0;
    out_ld    = 1'b0;
    ev_kind   = bpg_pkg::KIND_DONE;
    ev_dir    = 2'd0;
    ev_x      = 6'd0;
    ev_y      = 6'd0;
    ev_lane   = 6'd0;
    ev_cnt    = 5'(cnt_r);
    ev_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == bpg_pkg::OP_BEAT) state_nxt = S_MOVE;
          else if (in_grid) state_nxt = S_EDIT;
        end
      end
      S_MOVE: begin
        cmd       = bpg_pkg::CMD_MOVE;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd       = bpg_pkg::CMD_SCAN_LOAD;
        k_nxt     = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd   = bpg_pkg::CMD_SCAN_STEP;
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(MAX_HEADS - 2)) state_nxt = S_TURN;
      end
      S_TURN: begin
        cmd       = bpg_pkg::CMD_TURN;
        k_nxt     = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // Rotate the row past cell 0; hold while a hit waits for the output
        if (!emit_hit || out_free) begin
          cmd      = bpg_pkg::CMD_TAKE;
          pick_all = 1'b1;
          k_nxt    = k_r + KW'(1);
          if (emit_hit) begin
            out_ld  = 1'b1;
            ev_kind = bpg_pkg::KIND_WALL;
            ev_dir  = hd[0];
            ev_x    = 6'(hx[0]);
            ev_y    = 6'(hy[0]);
            ev_lane = (hd[0] == bpg_pkg::DIR_UP || hd[0] == bpg_pkg::DIR_DOWN) ?
                      6'(hx[0]) : 6'(hy[0]);
            ev_last = 1'b0;
          end
          if (k_r == KW'(MAX_HEADS - 1)) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EDIT: begin
        // Remove the highest match, else flag a full table, else append
        if (out_free) begin
          out_ld    = 1'b1;
          ev_x      = 6'(cx_r);
          ev_y      = 6'(cy_r);
          state_nxt = S_IDLE;
          if (any_match) begin
            cmd     = bpg_pkg::CMD_TAKE;
            pick_rm = 1'b1;
            cnt_nxt = cnt_r - NW'(1);
            ev_kind = bpg_pkg::KIND_REMOVED;
            ev_dir  = rm_dir;
            ev_cnt  = 5'(cnt_nxt);
          end else if (cnt_r == NW'(MAX_HEADS)) begin
            ev_kind = bpg_pkg::KIND_FULL;
            ev_dir  = nd_r;
          end else begin
            cmd      = bpg_pkg::CMD_TAKE;
            pick_add = 1'b1;
            nb_new   = 1'b1;
            cnt_nxt  = cnt_r + NW'(1);
            ev_kind  = bpg_pkg::KIND_ADDED;
            ev_dir   = nd_r;
            ev_cnt   = 5'(cnt_nxt);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wm1_r       <= CW'(dim_m1(bpg_pkg::DIM_RESET));
      hm1_r       <= CW'(dim_m1(bpg_pkg::DIM_RESET));
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          bpg_pkg::REG_GRID_WIDTH:  wm1_r <= CW'(dim_m1(cfg_data));
          bpg_pkg::REG_GRID_HEIGHT: hm1_r <= CW'(dim_m1(cfg_data));
          default: begin
          end
        endcase
      end
    end
  end

  // Latch the toggle operands; load the output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cx_r <= in_cx;
      cy_r <= in_cy;
      nd_r <= in_tdata[13:12];
    end
    if (out_ld) begin
      out_kind_r <= ev_kind;
      out_dir_r  <= ev_dir;
      out_x_r    <= ev_x;
      out_y_r    <= ev_y;
      out_lane_r <= ev_lane;
      out_cnt_r  <= ev_cnt;
      out_last_r <= ev_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_lane_r, out_y_r, out_x_r, out_dir_r};

`ifndef SYNTHESIS
  // Head count never exceeds the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(MAX_HEADS))
    else $error("head count above table size");

  // The output register is only reloaded when free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ld && out_valid_r) |-> out_tready)
    else $error("output register overwritten while stalled");

  // A removal drops the count by one
  a_remove_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIT && out_free && any_match) |=> (cnt_r == $past(cnt_r) - NW'(1)))
    else $error("removal did not decrement head count");
`endif

endmodule
